### hdl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/isa_pkg.sv
// types, codes and constants of the inverse square root block
// used by every module of the block
`timescale 1ns / 1ps

package isa_pkg;

  localparam logic [2:0] CFG_GUESS_MODE = 3'd0;
  localparam logic [2:0] CFG_MAGIC      = 3'd1;
  localparam logic [2:0] CFG_OUTER      = 3'd2;
  localparam logic [2:0] CFG_OFFSET     = 3'd3;
  localparam logic [2:0] CFG_SCALE      = 3'd4;

  localparam logic [1:0] GM_MAGIC = 2'd0;
  localparam logic [1:0] GM_RCP   = 2'd1;
  localparam logic [1:0] GM_SELF  = 2'd2;

  localparam logic [31:0] MAGIC_RESET  = 32'h5F3759DF;
  localparam logic [31:0] OUTER_RESET  = 32'h3F800000;
  localparam logic [31:0] OFFSET_RESET = 32'h3FC00000;
  localparam logic [31:0] SCALE_RESET  = 32'h3F000000;
  localparam logic [31:0] QNAN         = 32'h7FC00000;

  localparam logic [4:0] RCP_STEPS = 5'd26;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_SUB,
    FOP_RAW
  } fop_t;

  typedef struct packed {
    logic valid;
    fop_t op;
  } fpu_req_t;

  // unrounded value: mant bit 47 weighs 2^(exp-127)
  typedef struct packed {
    logic               sign;
    logic signed [12:0] exp;
    logic [47:0]        mant;
    logic               sticky;
    logic               is_nan;
    logic               is_inf;
    logic               is_zero;
  } fraw_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PH_RCP,
    PH_CX,
    PH_T1,
    PH_T2,
    PH_D,
    PH_U,
    PH_Y
  } phase_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

### hdl/isa_rcp.sv
// bit-serial reciprocal of a single-precision operand, one quotient bit a cycle
// depends on isa_pkg
`timescale 1ns / 1ps

module isa_rcp import isa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  output logic        done,
  output fraw_t       raw
);

  logic               busy;
  logic [4:0]         cnt;
  logic [23:0]        mn;
  logic [23:0]        rem;
  logic [25:0]        quo;
  logic signed [12:0] exq;
  logic               sign;
  logic               nan_f;
  logic               inf_f;
  logic               zero_f;

  logic [23:0] sig;
  logic [7:0]  eef;
  logic [5:0]  lz;
  logic [24:0] rem2;
  logic        qbit;

  always_comb begin
    sig  = {x[30:23] != 8'd0, x[22:0]};
    eef  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    lz   = lzc48({sig, 24'hFFFFFF});
    rem2 = {rem, 1'b0};
    qbit = rem2 >= {1'b0, mn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= RCP_STEPS;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mn     <= sig << lz;
      rem    <= 24'h400000;
      quo    <= '0;
      exq    <= $signed({5'b0, eef}) - $signed({7'b0, lz});
      sign   <= x[31];
      nan_f  <= (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      zero_f <= (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      inf_f  <= x[30:0] == 31'd0;
    end else if (busy) begin
      rem <= qbit ? 24'(rem2 - {1'b0, mn}) : rem2[23:0];
      quo <= {quo[24:0], qbit};
    end
  end

  always_comb begin
    raw.sign    = sign;
    raw.exp     = 13'sd254 - exq;
    raw.mant    = {quo, 22'b0};
    raw.sticky  = rem != 24'd0;
    raw.is_nan  = nan_f;
    raw.is_inf  = inf_f;
    raw.is_zero = zero_f;
  end

endmodule

### hdl/isa_fpu.sv
// shared single-precision mul/sub/raw-round unit, three stages, round to nearest even
// depends on isa_pkg
`timescale 1ns / 1ps

module isa_fpu import isa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fpu_req_t    req,
  input  logic [31:0] opa,
  input  logic [31:0] opb,
  input  fraw_t       raw_in,
  output logic        res_valid,
  output logic [31:0] res
);

  logic        sa, sb, sbn;
  logic [7:0]  ea, eb, eef_a, eef_b;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0] sig_a, sig_b;
  logic [47:0] prod;
  logic        a_big;
  logic [23:0] sig_big, sig_sml;
  logic [7:0]  eef_big, eef_sml, dsh;
  logic        sign_big;
  logic [48:0] vb, vs, vsh, vr;
  logic        lost_a;
  fraw_t       mul_raw, sub_raw, s1_next;

  logic        s1_valid;
  fraw_t       s1;

  // stage 1: operand unpack and raw arithmetic
  always_comb begin
    sa = opa[31];
    sb = opb[31];
    sbn = ~sb;
    ea = opa[30:23];
    eb = opb[30:23];
    fa = opa[22:0];
    fb = opb[22:0];
    nan_a  = (ea == 8'hFF) && (fa != 23'd0);
    nan_b  = (eb == 8'hFF) && (fb != 23'd0);
    inf_a  = (ea == 8'hFF) && (fa == 23'd0);
    inf_b  = (eb == 8'hFF) && (fb == 23'd0);
    zero_a = opa[30:0] == 31'd0;
    zero_b = opb[30:0] == 31'd0;
    sig_a  = {ea != 8'd0, fa};
    sig_b  = {eb != 8'd0, fb};
    eef_a  = (ea == 8'd0) ? 8'd1 : ea;
    eef_b  = (eb == 8'd0) ? 8'd1 : eb;

    prod = sig_a * sig_b;
    mul_raw.sign    = sa ^ sb;
    mul_raw.exp     = $signed({5'b0, eef_a}) + $signed({5'b0, eef_b}) - 13'sd126;
    mul_raw.mant    = prod;
    mul_raw.sticky  = 1'b0;
    mul_raw.is_nan  = nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
    mul_raw.is_inf  = inf_a | inf_b;
    mul_raw.is_zero = zero_a | zero_b;

    a_big    = opa[30:0] >= opb[30:0];
    sig_big  = a_big ? sig_a : sig_b;
    sig_sml  = a_big ? sig_b : sig_a;
    eef_big  = a_big ? eef_a : eef_b;
    eef_sml  = a_big ? eef_b : eef_a;
    sign_big = a_big ? sa : sbn;
    dsh      = eef_big - eef_sml;
    vb       = {1'b0, sig_big, 24'b0};
    vs       = {1'b0, sig_sml, 24'b0};
    lost_a   = |(vs & ~({49{1'b1}} << dsh));
    vsh      = (vs >> dsh) | {48'b0, lost_a};
    vr       = (sa == sbn) ? vb + vsh : vb - vsh;
    sub_raw.mant    = vr[48:1];
    sub_raw.sticky  = vr[0];
    sub_raw.exp     = $signed({5'b0, eef_big}) + 13'sd1;
    sub_raw.is_nan  = nan_a | nan_b | (inf_a & inf_b & (sa != sbn));
    sub_raw.is_inf  = inf_a | inf_b;
    sub_raw.is_zero = 1'b0;
    if (inf_a) begin
      sub_raw.sign = sa;
    end else if (inf_b) begin
      sub_raw.sign = sbn;
    end else if (vr == 49'd0) begin
      sub_raw.sign = sa & sbn;
    end else begin
      sub_raw.sign = sign_big;
    end

    unique case (req.op)
      FOP_MUL: s1_next = mul_raw;
      FOP_SUB: s1_next = sub_raw;
      FOP_RAW: s1_next = raw_in;
      default: s1_next = mul_raw;
    endcase
  end

  // stage 2: normalise, denormalise below the smallest exponent
  logic [5:0]         lz;
  logic signed [12:0] e1, shn;
  logic [47:0]        m1;
  logic [5:0]         sh_amt;
  fraw_t              s2_next;

  logic  s2_valid;
  fraw_t s2;

  always_comb begin
    lz  = lzc48(s1.mant);
    e1  = s1.exp - $signed({7'b0, lz});
    m1  = s1.mant << lz;
    shn = 13'sd1 - e1;
    sh_amt = (shn > 13'sd63) ? 6'd63 : shn[5:0];
    s2_next = s1;
    s2_next.is_zero = s1.is_zero | (s1.mant == 48'd0);
    if (e1 < 13'sd1) begin
      s2_next.mant   = m1 >> sh_amt;
      s2_next.sticky = s1.sticky | (|(m1 & ~({48{1'b1}} << sh_amt)));
      s2_next.exp    = '0;
    end else begin
      s2_next.mant = m1;
      s2_next.exp  = e1;
    end
  end

  // stage 3: round and pack
  logic        rnd_inc;
  logic [30:0] packed_mag;
  logic [31:0] res_next;

  always_comb begin
    rnd_inc    = s2.mant[23] & ((|s2.mant[22:0]) | s2.sticky | s2.mant[24]);
    packed_mag = {s2.exp[7:0], s2.mant[46:24]} + {30'b0, rnd_inc};
    priority if (s2.is_nan) begin
      res_next = QNAN;
    end else if (s2.is_inf || (s2.exp > 13'sd254)) begin
      res_next = {s2.sign, 8'hFF, 23'd0};
    end else if (s2.is_zero) begin
      res_next = {s2.sign, 31'd0};
    end else begin
      res_next = {s2.sign, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1  <= s1_next;
    s2  <= s2_next;
    res <= res_next;
  end

endmodule

### hdl/inverse_sqrt_approximator.sv
// inverse square root approximator: guess, then n newton steps on one shared float unit
// a reciprocal guess of x comes from the bit-serial divider, rounded on the float unit
// the scaled input is formed once on the float unit before the first step
// each step runs five dependent operations through the three-stage float unit
// one item at a time; next input transfer once the result is in the output register
// synchronous reset restores the register defaults and empties the pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"

module inverse_sqrt_approximator import isa_pkg::*; #(
  parameter int MAX_ITER = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] x_bits,
  input  logic [3:0]  iterations,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] y_bits,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW = $clog2(MAX_ITER + 1);
  localparam int IW = (CW > 4) ? CW : 4;

  logic [1:0]  guess_mode;
  logic [31:0] magic_constant;
  logic [31:0] coef_outer;
  logic [31:0] coef_offset;
  logic [31:0] coef_scale;

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [31:0]   x_q, y_q, cx_q, t_q, u_q;
  logic [CW-1:0] iter_left;

  logic          accept;
  logic          out_load;
  logic [IW-1:0] it_ext, max_ext;
  logic [CW-1:0] n_sat;
  logic [31:0]   guess;
  logic [31:0]   y_canon;

  fpu_req_t    fpu_req;
  logic [31:0] fpu_a, fpu_b;
  logic        fpu_valid;
  logic [31:0] fpu_res;
  logic        rcp_start, rcp_done;
  fraw_t       rcp_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      guess_mode     <= GM_MAGIC;
      magic_constant <= MAGIC_RESET;
      coef_outer     <= OUTER_RESET;
      coef_offset    <= OFFSET_RESET;
      coef_scale     <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GUESS_MODE: guess_mode     <= cfg_data[1:0];
        CFG_MAGIC:      magic_constant <= cfg_data;
        CFG_OUTER:      coef_outer     <= cfg_data;
        CFG_OFFSET:     coef_offset    <= cfg_data;
        CFG_SCALE:      coef_scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = state != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign rcp_start = accept && (guess_mode == GM_RCP);
  assign out_load  = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    it_ext  = IW'(iterations);
    max_ext = IW'(MAX_ITER);
    n_sat   = (it_ext > max_ext) ? max_ext[CW-1:0] : it_ext[CW-1:0];
    guess   = (guess_mode == GM_SELF) ? x_bits : magic_constant - {1'b0, x_bits[31:1]};
    y_canon = ((y_q[30:23] == 8'hFF) && (y_q[22:0] != 23'd0)) ? QNAN : y_q;
  end

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (guess_mode == GM_RCP) begin
            state_next = ST_DIV;
          end else if (n_sat == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_ISSUE;
            phase_next = PH_CX;
          end
        end
      end
      ST_DIV: begin
        if (rcp_done) begin
          state_next = ST_ISSUE;
          phase_next = PH_RCP;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (fpu_valid) begin
          state_next = ST_ISSUE;
          unique case (phase)
            PH_RCP: begin
              if (iter_left == '0) begin
                state_next = ST_FINISH;
              end else begin
                phase_next = PH_CX;
              end
            end
            PH_CX: phase_next = PH_T1;
            PH_T1: phase_next = PH_T2;
            PH_T2: phase_next = PH_D;
            PH_D:  phase_next = PH_U;
            PH_U:  phase_next = PH_Y;
            PH_Y: begin
              if (iter_left == CW'(1)) begin
                state_next = ST_FINISH;
              end else begin
                phase_next = PH_T1;
              end
            end
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // float unit request
  always_comb begin
    fpu_req.valid = state == ST_ISSUE;
    fpu_req.op    = FOP_MUL;
    fpu_a         = y_q;
    fpu_b         = t_q;
    unique case (phase)
      PH_RCP: fpu_req.op = FOP_RAW;
      PH_CX: begin
        fpu_a = coef_scale;
        fpu_b = x_q;
      end
      PH_T1: begin
        fpu_a = cx_q;
        fpu_b = y_q;
      end
      PH_T2: begin
        fpu_a = t_q;
        fpu_b = y_q;
      end
      PH_D: begin
        fpu_req.op = FOP_SUB;
        fpu_a      = coef_offset;
        fpu_b      = t_q;
      end
      PH_U: begin
        fpu_a = coef_outer;
        fpu_b = y_q;
      end
      PH_Y: begin
        fpu_a = u_q;
        fpu_b = t_q;
      end
      default: fpu_req.op = FOP_MUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_CX;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q       <= x_bits;
      iter_left <= n_sat;
      y_q       <= guess;
    end else if ((state == ST_WAIT) && fpu_valid) begin
      unique case (phase)
        PH_RCP: y_q  <= fpu_res;
        PH_CX:  cx_q <= fpu_res;
        PH_T1:  t_q  <= fpu_res;
        PH_T2:  t_q  <= fpu_res;
        PH_D:   t_q  <= fpu_res;
        PH_U:   u_q  <= fpu_res;
        PH_Y: begin
          y_q       <= fpu_res;
          iter_left <= iter_left - CW'(1);
        end
        default: y_q <= fpu_res;
      endcase
    end
    if (out_load) begin
      y_bits <= y_canon;
    end
  end

  isa_rcp u_rcp (
    .clk   (clk),
    .rst   (rst),
    .start (rcp_start),
    .x     (x_bits),
    .done  (rcp_done),
    .raw   (rcp_raw)
  );

  isa_fpu u_fpu (
    .clk       (clk),
    .rst       (rst),
    .req       (fpu_req),
    .opa       (fpu_a),
    .opb       (fpu_b),
    .raw_in    (rcp_raw),
    .res_valid (fpu_valid),
    .res       (fpu_res)
  );

  `ASSERT_CLK(a_fpu_only_when_waiting, clk, rst, fpu_valid |-> (state == ST_WAIT), "fpu result")
  `ASSERT_CLK(a_rcp_only_when_dividing, clk, rst, rcp_done |-> (state == ST_DIV), "rcp done")
  `ASSERT_CLK(a_busy_after_transfer, clk, rst, accept |=> in_stall, "not busy after transfer")
  `ASSERT_CLK(a_count_bound, clk, rst, (state != ST_IDLE) |-> (iter_left <= CW'(MAX_ITER)), "count")

endmodule
